[hdl/gcm_pkg.sv]
`default_nettype none
package gcm_pkg;
	localparam int VAL_W     = 16;
	localparam int CNT_W     = 3;
	localparam int CFG_IDX_W = 3;
	localparam int DIFF_W    = VAL_W + 1;
	localparam int DIV_W     = VAL_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_FIRST = 3'd1;
	localparam logic [VAL_W-1:0]     ONE_VALUE      = 16'd4096;
endpackage
`default_nettype wire

[hdl/gcm_front.sv]
`default_nettype none
module gcm_front #(
	parameter int MAX_STOPS  = 6,
	parameter int COLOR_BITS = 12
) (
	input  wire logic                                  clk,
	input  wire logic [3:0]                            en,
	input  wire logic signed [gcm_pkg::VAL_W-1:0]      sample_value,
	input  wire logic [gcm_pkg::CNT_W-1:0]             stop_count,
	input  wire logic [3*COLOR_BITS+gcm_pkg::VAL_W-1:0] stops [MAX_STOPS],
	output logic [COLOR_BITS+19:0]                     num_s4 [3],
	output logic [gcm_pkg::DIV_W-1:0]                  dvs_s4,
	output logic [2:0]                                 neg_s4,
	output logic [2:0]                                 sat_s4,
	output logic [COLOR_BITS-1:0]                      cl_s4 [3],
	output logic                                       dzero_s4,
	output logic                                       nograd_s4
);
	localparam int C   = COLOR_BITS;
	localparam int SW  = 3*C + gcm_pkg::VAL_W;
	localparam int IW  = $clog2(MAX_STOPS);
	localparam int NW  = C + 18;
	localparam int RW  = NW + 2;
	localparam int QB  = C + 1;
	localparam int VW  = gcm_pkg::VAL_W;
	localparam int DW  = gcm_pkg::DIFF_W;

	// Stage 1: bracketing search over the stops in use.
	logic [gcm_pkg::CNT_W-1:0] n;
	logic [IW-1:0]             l_c, r_c, m_c;
	logic [IW:0]               sum_c;
	logic                      nograd_c;

	logic signed [VW-1:0] s_s1, s_s2;
	logic [IW-1:0]        l_s1, r_s1;
	logic                 nograd_s1;

	always_comb begin
		n = (stop_count > gcm_pkg::CNT_W'(MAX_STOPS)) ? gcm_pkg::CNT_W'(MAX_STOPS) : stop_count;
		nograd_c = (n < gcm_pkg::CNT_W'(2));
		l_c = '0;
		r_c = nograd_c ? IW'(1) : IW'(n - gcm_pkg::CNT_W'(1));
		sum_c = '0;
		m_c = '0;
		for (int it = 0; it < 3; it++) begin
			if (r_c - l_c != IW'(1)) begin
				sum_c = {1'b0, r_c} + {1'b0, l_c};
				m_c = sum_c[IW:1];
				if ($signed(stops[m_c][SW-1 -: VW]) < sample_value)
					l_c = m_c;
				else
					r_c = m_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			s_s1      <= sample_value;
			l_s1      <= l_c;
			r_s1      <= r_c;
			nograd_s1 <= nograd_c;
		end
	end

	// Stage 2: fetch the pair, interval width and offset, sign folded.
	logic signed [VW-1:0] vl, vr;
	logic signed [DW-1:0] d_c, sd_c;
	logic [VW-1:0]        dabs_s2, dabs_s3;
	logic signed [DW-1:0] sd_s2;
	logic [C-1:0]         cl_s2 [3], cr_s2 [3], cl_s3 [3];
	logic                 nograd_s2, dzero_s2, nograd_s3, dzero_s3;

	always_comb begin
		vl   = $signed(stops[l_s1][SW-1 -: VW]);
		vr   = $signed(stops[r_s1][SW-1 -: VW]);
		d_c  = DW'(vr) - DW'(vl);
		sd_c = DW'(s_s1) - DW'(vl);
		if (d_c < 0) begin
			d_c  = -d_c;
			sd_c = -sd_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			s_s2      <= s_s1;
			dabs_s2   <= d_c[VW-1:0];
			sd_s2     <= sd_c;
			dzero_s2  <= (d_c == '0);
			nograd_s2 <= nograd_s1;
			for (int ch = 0; ch < 3; ch++) begin
				cl_s2[ch] <= stops[l_s1][(2-ch)*C +: C];
				cr_s2[ch] <= stops[r_s1][(2-ch)*C +: C];
			end
		end
	end

	// Stage 3: one multiplier per channel.
	logic signed [NW-1:0] num_s3 [3];
	logic signed [C:0]    dc [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			dc[ch] = $signed({1'b0, cr_s2[ch]}) - $signed({1'b0, cl_s2[ch]});
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int ch = 0; ch < 3; ch++)
				num_s3[ch] <= NW'(sd_s2 * dc[ch]);
			dabs_s3   <= dabs_s2;
			cl_s3     <= cl_s2;
			dzero_s3  <= dzero_s2 || (s_s2 == s_s2 && dabs_s2 == '0);
			nograd_s3 <= nograd_s2;
		end
	end

	// Stage 4: rounding offset, floor folded into an unsigned dividend,
	// and an early check for quotients too large to matter.
	logic signed [RW-1:0] a_c [3];
	logic [RW-1:0]        ap_c [3];
	logic [DW-1:0]        b_c;
	logic [RW-1:0]        lim_c;
	logic [2:0]           neg_c, sat_c;

	always_comb begin
		b_c   = {dabs_s3, 1'b0};
		lim_c = RW'({b_c, {QB{1'b0}}});
		for (int ch = 0; ch < 3; ch++) begin
			a_c[ch]   = $signed({num_s3[ch][NW-1], num_s3[ch], 1'b0})
				+ $signed(RW'(dabs_s3));
			neg_c[ch] = a_c[ch][RW-1];
			ap_c[ch]  = neg_c[ch] ? (RW'(-a_c[ch]) + RW'(b_c) - RW'(1)) : RW'(a_c[ch]);
			sat_c[ch] = (ap_c[ch] >= lim_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int ch = 0; ch < 3; ch++)
				num_s4[ch] <= ap_c[ch];
			dvs_s4    <= b_c;
			neg_s4    <= neg_c;
			sat_s4    <= sat_c;
			cl_s4     <= cl_s3;
			dzero_s4  <= dzero_s3;
			nograd_s4 <= nograd_s3;
		end
	end
endmodule
`default_nettype wire

[hdl/gcm_div.sv]
`default_nettype none
module gcm_div #(
	parameter int COLOR_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic [COLOR_BITS:0]           en,
	input  wire logic [COLOR_BITS+19:0]        dividend,
	input  wire logic [gcm_pkg::DIV_W-1:0]     divisor,
	input  wire logic                          neg,
	input  wire logic                          sat,
	input  wire logic [COLOR_BITS-1:0]         cl,
	output logic [COLOR_BITS:0]                quo,
	output logic                               neg_out,
	output logic                               sat_out,
	output logic [COLOR_BITS-1:0]              cl_out
);
	localparam int C  = COLOR_BITS;
	localparam int QB = C + 1;
	localparam int RW = C + 20;
	localparam int BW = gcm_pkg::DIV_W;

	logic [RW-1:0] rem_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic [BW-1:0] dvs_s [QB+1];
	logic          neg_s [QB+1];
	logic          sat_s [QB+1];
	logic [C-1:0]  cl_s  [QB+1];

	assign rem_s[0] = dividend;
	assign quo_s[0] = '0;
	assign dvs_s[0] = divisor;
	assign neg_s[0] = neg;
	assign sat_s[0] = sat;
	assign cl_s[0]  = cl;

	// One restoring step per stage, quotient MSB first.
	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [RW-1:0] sh;
		logic          ge;
		assign sh = RW'(dvs_s[k]) << (QB - 1 - k);
		assign ge = (rem_s[k] >= sh);
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k+1] <= ge ? (rem_s[k] - sh) : rem_s[k];
				quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
				dvs_s[k+1] <= dvs_s[k];
				neg_s[k+1] <= neg_s[k];
				sat_s[k+1] <= sat_s[k];
				cl_s[k+1]  <= cl_s[k];
			end
		end
	end

	assign quo     = quo_s[QB];
	assign neg_out = neg_s[QB];
	assign sat_out = sat_s[QB];
	assign cl_out  = cl_s[QB];
endmodule
`default_nettype wire

[hdl/gradient_color_mapper_top.sv]
// Gradient color mapper: maps a signed Q3.12 sample to a saturated RGB color by
// linear interpolation between the two color stops that bracket it (ties go to
// the lower interval, outside values extrapolate from the end pair). Stops are
// written through the configuration port in ascending order of value while the
// block is idle. One item is taken per clock unless in_stall is high. The
// pipeline is the search, fetch, multiply and rounding stages, followed by one
// restoring divider step per quotient bit and an output stage.
// Stalls propagate stage by stage, so empty stages still fill while the output
// waits. Fewer than two stops gives full green with no_gradient set.
`default_nettype none
module gradient_color_mapper_top #(
	parameter int MAX_STOPS  = 6,
	parameter int COLOR_BITS = 12
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic signed [gcm_pkg::VAL_W-1:0]        sample_value,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic [COLOR_BITS-1:0]                        red_level,
	output logic [COLOR_BITS-1:0]                        green_level,
	output logic [COLOR_BITS-1:0]                        blue_level,
	output logic                                         no_gradient,
	input  wire logic                                    cfg_we,
	input  wire logic [gcm_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [3*COLOR_BITS+gcm_pkg::VAL_W-1:0]  cfg_data
);
	localparam int C    = COLOR_BITS;
	localparam int SW   = 3*C + gcm_pkg::VAL_W;
	localparam int IW   = $clog2(MAX_STOPS);
	localparam int QB   = C + 1;
	localparam int NS   = 4 + QB + 1;
	localparam int LAST = NS - 1;
	localparam logic [C-1:0] CMAX = {C{1'b1}};

	// Configuration registers.
	logic [gcm_pkg::CNT_W-1:0] stop_count_q;
	logic [SW-1:0]             stops_q [MAX_STOPS];
	logic [gcm_pkg::CFG_IDX_W-1:0] widx;

	assign widx = cfg_index - gcm_pkg::CFG_STOP_FIRST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q <= gcm_pkg::CNT_W'(2);
			for (int i = 2; i < MAX_STOPS; i++)
				stops_q[i] <= '0;
			stops_q[0] <= SW'(CMAX);
			stops_q[1] <= {gcm_pkg::ONE_VALUE, CMAX, {(2*C){1'b0}}};
		end else if (cfg_we) begin
			if (cfg_index == gcm_pkg::CFG_STOP_COUNT)
				stop_count_q <= cfg_data[gcm_pkg::CNT_W-1:0];
			else if (widx < gcm_pkg::CFG_IDX_W'(MAX_STOPS))
				stops_q[widx[IW-1:0]] <= cfg_data;
		end
	end

	// Valid bits and per-stage advance.
	logic [NS-1:0] v_q;
	logic [NS-1:0] adv;

	always_comb begin
		adv[LAST] = !v_q[LAST] || !out_stall;
		for (int k = LAST - 1; k >= 0; k--)
			adv[k] = !v_q[k] || adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0])
				v_q[0] <= in_valid;
			for (int k = 1; k < NS; k++)
				if (adv[k])
					v_q[k] <= v_q[k-1];
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = v_q[LAST];

	// Front stages.
	logic [C+19:0]               num_s4 [3];
	logic [gcm_pkg::DIV_W-1:0]   dvs_s4;
	logic [2:0]                  neg_s4, sat_s4;
	logic [C-1:0]                cl_s4 [3];
	logic                        dzero_s4, nograd_s4;

	gcm_front #(.MAX_STOPS(MAX_STOPS), .COLOR_BITS(COLOR_BITS)) u_front (
		.clk          (clk),
		.en           (adv[3:0]),
		.sample_value (sample_value),
		.stop_count   (stop_count_q),
		.stops        (stops_q),
		.num_s4       (num_s4),
		.dvs_s4       (dvs_s4),
		.neg_s4       (neg_s4),
		.sat_s4       (sat_s4),
		.cl_s4        (cl_s4),
		.dzero_s4     (dzero_s4),
		.nograd_s4    (nograd_s4)
	);

	// Divider lanes, one per channel.
	logic [QB-1:0] quo   [3];
	logic [2:0]    neg_d, sat_d;
	logic [C-1:0]  cl_d  [3];

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		gcm_div #(.COLOR_BITS(COLOR_BITS)) u_div (
			.clk      (clk),
			.en       (adv[4 +: QB]),
			.dividend (num_s4[ch]),
			.divisor  (dvs_s4),
			.neg      (neg_s4[ch]),
			.sat      (sat_s4[ch]),
			.cl       (cl_s4[ch]),
			.quo      (quo[ch]),
			.neg_out  (neg_d[ch]),
			.sat_out  (sat_d[ch]),
			.cl_out   (cl_d[ch])
		);
	end

	// Flags ride alongside the divider.
	logic dzero_s [QB+1];
	logic nograd_s [QB+1];

	assign dzero_s[0]  = dzero_s4;
	assign nograd_s[0] = nograd_s4;

	for (genvar k = 0; k < QB; k++) begin : g_flag
		always_ff @(posedge clk) begin
			if (adv[4+k]) begin
				dzero_s[k+1]  <= dzero_s[k];
				nograd_s[k+1] <= nograd_s[k];
			end
		end
	end

	// Output stage: sign, offset by the left color, clamp.
	logic [C-1:0]        lvl_c [3];
	logic [QB-1:0]       mag;
	logic signed [QB:0]  qv;
	logic signed [C+2:0] res;

	always_comb begin
		mag = '0;
		qv  = '0;
		res = '0;
		for (int ch = 0; ch < 3; ch++) begin
			mag = sat_d[ch] ? {QB{1'b1}} : quo[ch];
			qv  = neg_d[ch] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			res = $signed({3'b000, cl_d[ch]}) + (C+3)'(qv);
			if (dzero_s[QB])
				lvl_c[ch] = cl_d[ch];
			else if (res < 0)
				lvl_c[ch] = '0;
			else if (res > $signed({3'b000, CMAX}))
				lvl_c[ch] = CMAX;
			else
				lvl_c[ch] = res[C-1:0];
			if (nograd_s[QB])
				lvl_c[ch] = (ch == 1) ? CMAX : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[LAST]) begin
			red_level   <= lvl_c[0];
			green_level <= lvl_c[1];
			blue_level  <= lvl_c[2];
			no_gradient <= nograd_s[QB];
		end
	end
endmodule
`default_nettype wire
